### src/vng_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vng_pkg
// Shared codes, widths and types of the vertex normal generator.
// ----------------------------------------------------------------------------
package vng_pkg;

    localparam logic [1:0] MODE_CLEAR = 2'd0;
    localparam logic [1:0] MODE_LOAD  = 2'd1;
    localparam logic [1:0] MODE_TRI   = 2'd2;
    localparam logic [1:0] MODE_READ  = 2'd3;

    localparam logic [1:0] REG_VERTEX_COUNT = 2'd0;
    localparam logic [1:0] REG_VALID_THR    = 2'd1;
    localparam logic [1:0] REG_DEGEN_THR    = 2'd2;

    localparam int VC_W      = 13;
    localparam int VT_W      = 30;
    localparam int DT_W      = 63;
    localparam int CFG_W     = 63;
    localparam int IDX_W     = 12;
    localparam int NRM_W     = 16;
    localparam int ACC_W     = 64;
    localparam int RAD_W     = 64;
    localparam int ROOT_W    = 32;
    localparam int DIV_NUM_W = 48;
    localparam int DIV_Q_W   = 16;

    localparam logic [VC_W-1:0] VC_RESET = 13'd0;
    localparam logic [VT_W-1:0] VT_RESET = 30'd268;
    localparam logic [DT_W-1:0] DT_RESET = 63'd184467440737;

    localparam logic signed [NRM_W-1:0] UNIT_Q14 = 16'sd16384;

    typedef logic signed [NRM_W-1:0] nrm_t;
    typedef logic signed [ACC_W-1:0] acc_t;

endpackage

### src/vertex_normal_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_normal_generator
// Area-weighted vertex normals held in two synchronous RAMs.
// ----------------------------------------------------------------------------
// Usage:
//   item_* channel (valid/ready) carries commands: clear flags, load vertex,
//   triangle, read normal. Only a read yields a result item on result_*.
//   cfg_we/cfg_index/cfg_data writes the vertex count, valid_threshold and
//   degenerate_threshold; the user must write them only while the block
//   is idle, which the block does not enforce. One item is worked on at a
//   time; item_ready is high in the idle state. A triangle with a corner
//   outside the vertex count is skipped. A non-degenerate generated read
//   shifts the magnitudes right until the largest is under 2^31, then
//   runs the 32-step square root and three 16-step divisions. The
//   shared multiplier serves loads, reads and triangles; the accumulator
//   RAM has one write port and one read port.
//   A finished result waits in the output register; a stalled receiver
//   holds the block only when the next result is ready to be presented.
//   Reset clears flags and control state and restores the configuration;
//   the vertex RAMs are not cleared, loading a vertex zeroes its accumulator.
// ----------------------------------------------------------------------------
module vertex_normal_generator
    import vng_pkg::*;
#(
    parameter int MAX_VERTICES  = 4096,
    parameter int POSITION_BITS = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_ready,
    input  logic [1:0]                      mode,
    input  logic [IDX_W-1:0]                vertex_index,
    input  logic signed [POSITION_BITS-1:0] pos_x,
    input  logic signed [POSITION_BITS-1:0] pos_y,
    input  logic signed [POSITION_BITS-1:0] pos_z,
    input  logic signed [NRM_W-1:0]         given_normal_x,
    input  logic signed [NRM_W-1:0]         given_normal_y,
    input  logic signed [NRM_W-1:0]         given_normal_z,
    input  logic [IDX_W-1:0]                corner_b,
    input  logic [IDX_W-1:0]                corner_c,
    output logic                            result_valid,
    input  logic                            result_ready,
    output logic signed [NRM_W-1:0]         normal_x,
    output logic signed [NRM_W-1:0]         normal_y,
    output logic signed [NRM_W-1:0]         normal_z,
    output logic                            generated,
    output logic                            index_fault,
    input  logic                            cfg_we,
    input  logic [1:0]                      cfg_index,
    input  logic [CFG_W-1:0]                cfg_data
);

    localparam int AW    = $clog2(MAX_VERTICES);
    localparam int PB    = POSITION_BITS;
    localparam int VTX_W = 3 * PB + 3 * NRM_W;
    localparam int ACC3_W = 3 * ACC_W;
    localparam int MUL_W = 33;
    localparam int PRD_W = 2 * MUL_W;

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_SQ0  = 5'd1;
    localparam logic [4:0] S_SQ1  = 5'd2;
    localparam logic [4:0] S_SQ2  = 5'd3;
    localparam logic [4:0] S_SQ3  = 5'd4;
    localparam logic [4:0] S_SQ4  = 5'd5;
    localparam logic [4:0] S_T0   = 5'd6;
    localparam logic [4:0] S_T1   = 5'd7;
    localparam logic [4:0] S_T2   = 5'd8;
    localparam logic [4:0] S_T3   = 5'd9;
    localparam logic [4:0] S_T4   = 5'd10;
    localparam logic [4:0] S_T5   = 5'd11;
    localparam logic [4:0] S_T6   = 5'd12;
    localparam logic [4:0] S_T7   = 5'd13;
    localparam logic [4:0] S_T8   = 5'd14;
    localparam logic [4:0] S_T9   = 5'd15;
    localparam logic [4:0] S_T10  = 5'd16;
    localparam logic [4:0] S_TA   = 5'd17;
    localparam logic [4:0] S_TW   = 5'd18;
    localparam logic [4:0] S_PR   = 5'd19;
    localparam logic [4:0] S_PD   = 5'd20;
    localparam logic [4:0] S_R0   = 5'd21;
    localparam logic [4:0] S_R1   = 5'd22;
    localparam logic [4:0] S_SH   = 5'd23;
    localparam logic [4:0] S_RTS  = 5'd24;
    localparam logic [4:0] S_RTW  = 5'd25;
    localparam logic [4:0] S_DVS  = 5'd26;
    localparam logic [4:0] S_DVW  = 5'd27;
    localparam logic [4:0] S_OUT  = 5'd28;

    // configuration
    logic [VC_W-1:0] vcount_reg;
    logic [VT_W-1:0] valid_thr_reg;
    logic [DT_W-1:0] degen_thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vcount_reg    <= VC_RESET;
            valid_thr_reg <= VT_RESET;
            degen_thr_reg <= DT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VERTEX_COUNT: vcount_reg    <= cfg_data[VC_W-1:0];
                REG_VALID_THR:    valid_thr_reg <= cfg_data[VT_W-1:0];
                REG_DEGEN_THR:    degen_thr_reg <= cfg_data[DT_W-1:0];
                default:          ;
            endcase
        end
    end

    function automatic logic in_use(input logic [IDX_W-1:0] idx,
                                    input logic [VC_W-1:0] vc);
        in_use = (32'(idx) < 32'(vc)) && (32'(idx) < 32'(MAX_VERTICES));
    endfunction

    function automatic logic signed [31:0] clamp_edge(input logic signed [33:0] d);
        if (d > 34'sd2147483647)
            clamp_edge = 32'sd2147483647;
        else if (d < -34'sd2147483647)
            clamp_edge = -32'sd2147483647;
        else
            clamp_edge = d[31:0];
    endfunction

    function automatic acc_t sat_add(input acc_t a, input acc_t b);
        logic signed [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(b);
        if (s[ACC_W] != s[ACC_W-1])
            sat_add = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            sat_add = s[ACC_W-1:0];
    endfunction

    logic [4:0] state_reg;
    logic [4:0] state_next;

    logic [1:0]        mode_reg;
    logic [IDX_W-1:0]  vi_reg;
    logic [IDX_W-1:0]  b_reg;
    logic [IDX_W-1:0]  c_reg;
    nrm_t              nrm_reg [3];
    logic              invalid_flag_reg;
    logic              tri_flag_reg;
    logic [1:0]        k_reg;
    logic              pass2_reg;

    logic signed [PB-1:0] pa_x_reg, pa_y_reg, pa_z_reg;
    logic signed [31:0]   e1x_reg, e1y_reg, e1z_reg, e2x_reg, e2y_reg, e2z_reg;
    acc_t                 tmp_reg, fx_reg, fy_reg, fz_reg;
    logic [ACC_W-1:0]     mag_reg [3];
    logic [ACC_W-1:0]     mx_reg;
    logic [2:0]           neg_reg;
    logic                 big_reg;
    logic [PRD_W-1:0]     sum_reg;
    logic [ROOT_W-1:0]    root_reg;

    nrm_t res_n_reg [3];
    logic res_gen_reg;
    logic res_fault_reg;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PRD_W-1:0] prod_reg;

    logic accept;
    assign item_ready = (state_reg == S_IDLE);
    assign accept     = item_valid && item_ready;

    // RAMs
    logic              vtx_we;
    logic [AW-1:0]     vtx_raddr;
    logic [VTX_W-1:0]  vtx_rdata;
    logic              acc_we;
    logic [AW-1:0]     acc_waddr;
    logic [AW-1:0]     acc_raddr;
    logic [ACC3_W-1:0] acc_wdata;
    logic [ACC3_W-1:0] acc_rdata;
    logic [IDX_W-1:0]  corner_idx;

    logic load_ok;
    assign load_ok = (32'(vertex_index) < 32'(MAX_VERTICES));

    assign vtx_we = accept && (mode == MODE_LOAD) && load_ok;

    always_comb
    begin
        case (k_reg)
            2'd0:    corner_idx = vi_reg;
            2'd1:    corner_idx = b_reg;
            default: corner_idx = c_reg;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_T1:    vtx_raddr = AW'(b_reg);
            S_T2:    vtx_raddr = AW'(c_reg);
            default: vtx_raddr = AW'(vi_reg);
        endcase
    end

    assign acc_raddr = (state_reg == S_TA) ? AW'(corner_idx) : AW'(vi_reg);
    assign acc_we    = vtx_we || (state_reg == S_TW);
    assign acc_waddr = (state_reg == S_TW) ? AW'(corner_idx) : AW'(vertex_index);

    always_comb
    begin
        if (state_reg == S_TW)
        begin
            acc_wdata = {sat_add(acc_t'(acc_rdata[3*ACC_W-1:2*ACC_W]), fz_reg),
                         sat_add(acc_t'(acc_rdata[2*ACC_W-1:ACC_W]), fy_reg),
                         sat_add(acc_t'(acc_rdata[ACC_W-1:0]), fx_reg)};
        end
        else
        begin
            acc_wdata = '0;
        end
    end

    vng_ram #(.WIDTH(VTX_W), .DEPTH(MAX_VERTICES)) u_vtx_ram (
        .clk   (clk),
        .we    (vtx_we),
        .waddr (AW'(vertex_index)),
        .wdata ({given_normal_z, given_normal_y, given_normal_x, pos_z, pos_y, pos_x}),
        .raddr (vtx_raddr),
        .rdata (vtx_rdata)
    );

    vng_ram #(.WIDTH(ACC3_W), .DEPTH(MAX_VERTICES)) u_acc_ram (
        .clk   (clk),
        .we    (acc_we),
        .waddr (acc_waddr),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    logic signed [PB-1:0] rd_px, rd_py, rd_pz;
    assign rd_px = vtx_rdata[PB-1:0];
    assign rd_py = vtx_rdata[2*PB-1:PB];
    assign rd_pz = vtx_rdata[3*PB-1:2*PB];

    // square root and divider
    logic                 sqrt_start, sqrt_done;
    logic [ROOT_W-1:0]    sqrt_root;
    logic                 div_start, div_done;
    logic [DIV_Q_W-1:0]   div_quot;
    logic [DIV_NUM_W-1:0] div_num;

    assign sqrt_start = (state_reg == S_RTS);
    assign div_start  = (state_reg == S_DVS);
    assign div_num    = (DIV_NUM_W'(mag_reg[k_reg][30:0]) << 14)
                      + DIV_NUM_W'(root_reg >> 1);

    vng_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (sum_reg[RAD_W-1:0]),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    vng_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (root_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // shared multiplier
    logic [1:0] sq_idx;
    always_comb
    begin
        case (state_reg)
            S_SQ1:   sq_idx = 2'd1;
            S_SQ2:   sq_idx = 2'd2;
            default: sq_idx = 2'd0;
        endcase
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_SQ0, S_SQ1, S_SQ2:
            begin
                if (mode_reg == MODE_LOAD)
                    mul_a = MUL_W'(nrm_reg[sq_idx]);
                else
                    mul_a = $signed({1'b0, mag_reg[sq_idx][31:0]});
                mul_b = mul_a;
            end
            S_T4: begin mul_a = MUL_W'(e1y_reg); mul_b = MUL_W'(e2z_reg); end
            S_T5: begin mul_a = MUL_W'(e1z_reg); mul_b = MUL_W'(e2y_reg); end
            S_T6: begin mul_a = MUL_W'(e1z_reg); mul_b = MUL_W'(e2x_reg); end
            S_T7: begin mul_a = MUL_W'(e1x_reg); mul_b = MUL_W'(e2z_reg); end
            S_T8: begin mul_a = MUL_W'(e1x_reg); mul_b = MUL_W'(e2y_reg); end
            S_T9: begin mul_a = MUL_W'(e1y_reg); mul_b = MUL_W'(e2x_reg); end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // acc magnitudes at read
    acc_t             rd_acc [3];
    logic [ACC_W-1:0] rd_mag [3];
    logic [ACC_W-1:0] rd_mx01;
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            rd_acc[i] = acc_rdata[i*ACC_W +: ACC_W];
            rd_mag[i] = rd_acc[i][ACC_W-1] ? (ACC_W'(0) - ACC_W'(rd_acc[i]))
                                           : ACC_W'(rd_acc[i]);
        end
        rd_mx01 = (rd_mag[0] > rd_mag[1]) ? rd_mag[0] : rd_mag[1];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (mode)
                        MODE_LOAD: state_next = load_ok ? S_SQ0 : S_IDLE;
                        MODE_TRI:
                        begin
                            if (in_use(vertex_index, vcount_reg)
                                && in_use(corner_b, vcount_reg)
                                && in_use(corner_c, vcount_reg))
                                state_next = S_T0;
                        end
                        MODE_READ:
                        begin
                            if (!in_use(vertex_index, vcount_reg))
                                state_next = S_OUT;
                            else if (!tri_flag_reg || !invalid_flag_reg)
                                state_next = S_PR;
                            else
                                state_next = S_R0;
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_SQ0: state_next = S_SQ1;
            S_SQ1: state_next = S_SQ2;
            S_SQ2: state_next = S_SQ3;
            S_SQ3: state_next = S_SQ4;
            S_SQ4:
            begin
                if (mode_reg == MODE_LOAD)
                    state_next = S_IDLE;
                else if (pass2_reg)
                    state_next = S_RTS;
                else if (!big_reg && (sum_reg <= PRD_W'(degen_thr_reg)))
                    state_next = S_OUT;
                else
                    state_next = S_SH;
            end
            S_T0:  state_next = S_T1;
            S_T1:  state_next = S_T2;
            S_T2:  state_next = S_T3;
            S_T3:  state_next = S_T4;
            S_T4:  state_next = S_T5;
            S_T5:  state_next = S_T6;
            S_T6:  state_next = S_T7;
            S_T7:  state_next = S_T8;
            S_T8:  state_next = S_T9;
            S_T9:  state_next = S_T10;
            S_T10: state_next = S_TA;
            S_TA:  state_next = S_TW;
            S_TW:  state_next = (k_reg == 2'd2) ? S_IDLE : S_TA;
            S_PR:  state_next = S_PD;
            S_PD:  state_next = S_OUT;
            S_R0:  state_next = S_R1;
            S_R1:  state_next = S_SQ0;
            S_SH:  state_next = (mx_reg[ACC_W-1:31] != '0) ? S_SH : S_SQ0;
            S_RTS: state_next = S_RTW;
            S_RTW:
            begin
                if (sqrt_done)
                    state_next = (sqrt_root == '0) ? S_OUT : S_DVS;
            end
            S_DVS: state_next = S_DVW;
            S_DVW:
            begin
                if (div_done)
                    state_next = (k_reg == 2'd2) ? S_OUT : S_DVS;
            end
            S_OUT:
            begin
                if (!result_valid || result_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            invalid_flag_reg <= 1'b0;
            tri_flag_reg     <= 1'b0;
            k_reg            <= 2'd0;
            pass2_reg        <= 1'b0;
            result_valid     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept && (mode == MODE_CLEAR))
            begin
                invalid_flag_reg <= 1'b0;
                tri_flag_reg     <= 1'b0;
            end
            if (accept && (mode == MODE_TRI))
                tri_flag_reg <= 1'b1;
            if ((state_reg == S_SQ4) && (mode_reg == MODE_LOAD)
                && (sum_reg <= PRD_W'(valid_thr_reg)))
                invalid_flag_reg <= 1'b1;

            if (accept)
                pass2_reg <= 1'b0;
            else if ((state_reg == S_SH) && (mx_reg[ACC_W-1:31] == '0))
                pass2_reg <= 1'b1;

            if (state_reg == S_T10 || state_reg == S_RTW)
                k_reg <= 2'd0;
            else if (state_reg == S_TW || (state_reg == S_DVW && div_done))
                k_reg <= k_reg + 2'd1;

            if (state_reg == S_OUT && (!result_valid || result_ready))
                result_valid <= 1'b1;
            else if (result_ready)
                result_valid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= mode;
            vi_reg     <= vertex_index;
            b_reg      <= corner_b;
            c_reg      <= corner_c;
            nrm_reg[0] <= given_normal_x;
            nrm_reg[1] <= given_normal_y;
            nrm_reg[2] <= given_normal_z;
            res_n_reg[0]  <= '0;
            res_n_reg[1]  <= '0;
            res_n_reg[2]  <= '0;
            res_gen_reg   <= 1'b0;
            res_fault_reg <= !in_use(vertex_index, vcount_reg);
        end

        case (state_reg)
            S_SQ1: sum_reg <= PRD_W'(unsigned'(prod_reg));
            S_SQ2, S_SQ3: sum_reg <= sum_reg + PRD_W'(unsigned'(prod_reg));
            S_SQ4:
            begin
                if (mode_reg == MODE_READ && !pass2_reg && !big_reg
                    && (sum_reg <= PRD_W'(degen_thr_reg)))
                begin
                    res_n_reg[2] <= UNIT_Q14;
                    res_gen_reg  <= 1'b1;
                end
            end
            S_T1:
            begin
                pa_x_reg <= rd_px;
                pa_y_reg <= rd_py;
                pa_z_reg <= rd_pz;
            end
            S_T2:
            begin
                e1x_reg <= clamp_edge(34'(rd_px) - 34'(pa_x_reg));
                e1y_reg <= clamp_edge(34'(rd_py) - 34'(pa_y_reg));
                e1z_reg <= clamp_edge(34'(rd_pz) - 34'(pa_z_reg));
            end
            S_T3:
            begin
                e2x_reg <= clamp_edge(34'(rd_px) - 34'(pa_x_reg));
                e2y_reg <= clamp_edge(34'(rd_py) - 34'(pa_y_reg));
                e2z_reg <= clamp_edge(34'(rd_pz) - 34'(pa_z_reg));
            end
            S_T5, S_T7, S_T9: tmp_reg <= prod_reg[ACC_W-1:0];
            S_T6:  fx_reg <= tmp_reg - acc_t'(prod_reg[ACC_W-1:0]);
            S_T8:  fy_reg <= tmp_reg - acc_t'(prod_reg[ACC_W-1:0]);
            S_T10: fz_reg <= tmp_reg - acc_t'(prod_reg[ACC_W-1:0]);
            S_PD:
            begin
                res_n_reg[0] <= vtx_rdata[3*PB +: NRM_W];
                res_n_reg[1] <= vtx_rdata[3*PB+NRM_W +: NRM_W];
                res_n_reg[2] <= vtx_rdata[3*PB+2*NRM_W +: NRM_W];
            end
            S_R1:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    mag_reg[i] <= rd_mag[i];
                    neg_reg[i] <= rd_acc[i][ACC_W-1];
                end
                mx_reg  <= (rd_mx01 > rd_mag[2]) ? rd_mx01 : rd_mag[2];
                big_reg <= (rd_mag[0][ACC_W-1:32] != '0) || (rd_mag[1][ACC_W-1:32] != '0)
                        || (rd_mag[2][ACC_W-1:32] != '0);
            end
            S_SH:
            begin
                // shift until the largest magnitude is below 2^31
                if (mx_reg[ACC_W-1:31] != '0)
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= mag_reg[i] >> 1;
                    mx_reg <= mx_reg >> 1;
                end
            end
            S_RTW:
            begin
                if (sqrt_done)
                begin
                    root_reg <= sqrt_root;
                    res_gen_reg <= 1'b1;
                    if (sqrt_root == '0)
                        res_n_reg[2] <= UNIT_Q14;
                end
            end
            S_DVW:
            begin
                if (div_done)
                    res_n_reg[k_reg] <= neg_reg[k_reg] ? -nrm_t'(div_quot) : nrm_t'(div_quot);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_OUT && (!result_valid || result_ready))
        begin
            normal_x    <= res_n_reg[0];
            normal_y    <= res_n_reg[1];
            normal_z    <= res_n_reg[2];
            generated   <= res_gen_reg;
            index_fault <= res_fault_reg;
        end
    end

    // checks
    a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && index_fault |-> normal_x == 0 && normal_y == 0
                                        && normal_z == 0 && !generated)
        else $error("index fault result carries a nonzero normal");

    a_sqrt_awaited: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> state_reg == S_RTW)
        else $error("square root finished outside its wait state");

    a_div_awaited: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DVW)
        else $error("division finished outside its wait state");

    a_gen_unit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && generated |-> normal_x <= 16384 && normal_x >= -16384
            && normal_y <= 16384 && normal_y >= -16384
            && normal_z <= 16384 && normal_z >= -16384)
        else $error("generated normal component out of unit range");

endmodule

### src/vng_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vng_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module vng_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### src/vng_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vng_isqrt
// Iterative integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module vng_isqrt
    import vng_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [RAD_W-1:0]  radicand,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    logic [RAD_W-1:0] n_reg;
    logic [RAD_W-1:0] res_reg;
    logic [RAD_W-1:0] bit_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [RAD_W-1:0] trial;
    logic             take;
    logic             last;

    assign trial = res_reg + bit_reg;
    assign take  = (n_reg >= trial);
    assign last  = (bit_reg == RAD_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            n_reg   <= radicand;
            res_reg <= '0;
            bit_reg <= RAD_W'(1) << (RAD_W - 2);
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                n_reg   <= n_reg - trial;
                res_reg <= (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[ROOT_W-1:0];

endmodule

### src/vng_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vng_div
// Restoring divider, one quotient bit per cycle. The quotient
// must fit in DIV_Q_W bits.
// ----------------------------------------------------------------------------
module vng_div
    import vng_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [ROOT_W-1:0]    den,
    output logic                 done,
    output logic [DIV_Q_W-1:0]   quot
);

    localparam int K_W = $clog2(DIV_Q_W);

    logic [DIV_NUM_W-1:0] rem_reg;
    logic [ROOT_W-1:0]    den_reg;
    logic [K_W-1:0]       k_reg;
    logic [DIV_Q_W-1:0]   q_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_NUM_W-1:0] trial;
    logic                 last;

    assign trial = DIV_NUM_W'(den_reg) << k_reg;
    assign last  = (k_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && last)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            den_reg <= den;
            k_reg   <= K_W'(DIV_Q_W - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg        <= rem_reg - trial;
                q_reg[k_reg]   <= 1'b1;
            end
            k_reg <= k_reg - K_W'(1);
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives command items into vertex_normal_generator, predicts every read
// normal from a behavioral copy of the vertex stores, and compares results
// field by field under random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import vng_pkg::*;

    localparam int NV          = 4096;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE      = 200;

    typedef struct packed {
        nrm_t x;
        nrm_t y;
        nrm_t z;
        logic gen;
        logic fault;
    } normal_rec_t;

    class normal_scoreboard;
        logic signed [23:0] px[NV];
        logic signed [23:0] py[NV];
        logic signed [23:0] pz[NV];
        logic [47:0]        gnorm[NV];
        acc_t               ax[NV];
        acc_t               ay[NV];
        acc_t               az[NV];
        bit                 invalid_seen;
        bit                 tri_seen;
        logic [VC_W-1:0]    vcount;
        logic [VT_W-1:0]    vthr;
        logic [DT_W-1:0]    dthr;
        normal_rec_t        pending[$];
        int                 errors;

        function new();
            for (int i = 0; i < NV; i++)
            begin
                ax[i] = 0;
                ay[i] = 0;
                az[i] = 0;
            end
            vcount = VC_RESET;
            vthr   = VT_RESET;
            dthr   = DT_RESET;
            errors = 0;
        endfunction

        function void report(string msg);
            $display("ERROR @%0t: %s", $realtime, msg);
            errors++;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CFG_W-1:0] d);
            case (idx)
                REG_VERTEX_COUNT: vcount = d[VC_W-1:0];
                REG_VALID_THR:    vthr   = d[VT_W-1:0];
                REG_DEGEN_THR:    dthr   = d[DT_W-1:0];
                default: ;
            endcase
        endfunction

        function int in_use();
            return (vcount < NV) ? int'(vcount) : NV;
        endfunction

        function acc_t sat_sum(acc_t a, acc_t b);
            logic signed [64:0] s;
            s = {a[63], a} + {b[63], b};
            if (s[64] != s[63])
                return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
            return s[63:0];
        endfunction

        function acc_t clamp_edge(acc_t e);
            if (e > 64'sd2147483647)
                return 64'sd2147483647;
            if (e < -64'sd2147483647)
                return -64'sd2147483647;
            return e;
        endfunction

        function logic [63:0] int_sqrt(logic [63:0] n);
            logic [63:0] res;
            logic [63:0] b;
            res = 0;
            b   = 64'd1 << 62;
            while (b > n)
                b >>= 2;
            while (b != 0)
            begin
                if (n >= res + b)
                begin
                    n   = n - (res + b);
                    res = (res >> 1) + b;
                end
                else
                    res = res >> 1;
                b >>= 2;
            end
            return res;
        endfunction

        function normal_rec_t unit_normal(acc_t a0, acc_t a1, acc_t a2);
            acc_t         a[3];
            logic [63:0]  m[3];
            logic [127:0] sq;
            logic [63:0]  mx;
            logic [63:0]  l2;
            logic [63:0]  r;
            logic [63:0]  q;
            nrm_t         n[3];
            int           s;
            normal_rec_t  rec;
            a[0] = a0;
            a[1] = a1;
            a[2] = a2;
            sq = 0;
            mx = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = a[i][63] ? (~a[i] + 64'd1) : a[i];
                sq = sq + {64'd0, m[i]} * {64'd0, m[i]};
                if (m[i] > mx)
                    mx = m[i];
            end
            rec.gen   = 1'b1;
            rec.fault = 1'b0;
            rec.x = 0;
            rec.y = 0;
            rec.z = UNIT_Q14;
            if (sq <= {65'd0, dthr})
                return rec;
            s = 0;
            while ((mx >> s) >= 64'h8000_0000)
                s++;
            l2 = 0;
            for (int i = 0; i < 3; i++)
            begin
                m[i] = m[i] >> s;
                l2 = l2 + m[i] * m[i];
            end
            r = int_sqrt(l2);
            if (r == 0)
                return rec;
            for (int i = 0; i < 3; i++)
            begin
                q = (m[i] * 64'd16384 + (r >> 1)) / r;
                n[i] = a[i][63] ? -q[15:0] : q[15:0];
            end
            rec.x = n[0];
            rec.y = n[1];
            rec.z = n[2];
            return rec;
        endfunction

        function void note_item(logic [1:0] md, logic [IDX_W-1:0] vi,
                                logic signed [23:0] x, logic signed [23:0] y,
                                logic signed [23:0] z, nrm_t gx, nrm_t gy, nrm_t gz,
                                logic [IDX_W-1:0] cb, logic [IDX_W-1:0] cc);
            int          cnt;
            acc_t        e1x, e1y, e1z, e2x, e2y, e2z, fx, fy, fz;
            acc_t        gx64, gy64, gz64;
            logic [63:0] len2;
            int          c[3];
            normal_rec_t rec;
            cnt = in_use();
            case (md)
                MODE_CLEAR:
                begin
                    invalid_seen = 0;
                    tri_seen     = 0;
                end
                MODE_LOAD:
                begin
                    px[vi] = x;
                    py[vi] = y;
                    pz[vi] = z;
                    gnorm[vi] = {gz, gy, gx};
                    ax[vi] = 0;
                    ay[vi] = 0;
                    az[vi] = 0;
                    gx64 = gx;
                    gy64 = gy;
                    gz64 = gz;
                    len2 = gx64 * gx64 + gy64 * gy64 + gz64 * gz64;
                    if (len2 <= {34'd0, vthr})
                        invalid_seen = 1;
                end
                MODE_TRI:
                begin
                    tri_seen = 1;
                    if (vi < cnt && cb < cnt && cc < cnt)
                    begin
                        e1x = clamp_edge(acc_t'(px[cb]) - acc_t'(px[vi]));
                        e1y = clamp_edge(acc_t'(py[cb]) - acc_t'(py[vi]));
                        e1z = clamp_edge(acc_t'(pz[cb]) - acc_t'(pz[vi]));
                        e2x = clamp_edge(acc_t'(px[cc]) - acc_t'(px[vi]));
                        e2y = clamp_edge(acc_t'(py[cc]) - acc_t'(py[vi]));
                        e2z = clamp_edge(acc_t'(pz[cc]) - acc_t'(pz[vi]));
                        fx = e1y * e2z - e1z * e2y;
                        fy = e1z * e2x - e1x * e2z;
                        fz = e1x * e2y - e1y * e2x;
                        c[0] = vi;
                        c[1] = cb;
                        c[2] = cc;
                        for (int k = 0; k < 3; k++)
                        begin
                            ax[c[k]] = sat_sum(ax[c[k]], fx);
                            ay[c[k]] = sat_sum(ay[c[k]], fy);
                            az[c[k]] = sat_sum(az[c[k]], fz);
                        end
                    end
                end
                default:
                begin
                    if (vi >= cnt)
                    begin
                        rec = '0;
                        rec.fault = 1'b1;
                    end
                    else if (!tri_seen || !invalid_seen)
                    begin
                        rec.x = gnorm[vi][15:0];
                        rec.y = gnorm[vi][31:16];
                        rec.z = gnorm[vi][47:32];
                        rec.gen = 0;
                        rec.fault = 0;
                    end
                    else
                        rec = unit_normal(ax[vi], ay[vi], az[vi]);
                    pending = {pending, rec};
                end
            endcase
        endfunction

        function void check_result(normal_rec_t got);
            normal_rec_t w;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result %p", got));
                return;
            end
            w = pending.pop_front();
            if (got.x !== w.x)
                report($sformatf("normal_x got %0d want %0d", got.x, w.x));
            if (got.y !== w.y)
                report($sformatf("normal_y got %0d want %0d", got.y, w.y));
            if (got.z !== w.z)
                report($sformatf("normal_z got %0d want %0d", got.z, w.z));
            if (got.gen !== w.gen)
                report($sformatf("generated got %b want %b", got.gen, w.gen));
            if (got.fault !== w.fault)
                report($sformatf("index_fault got %b want %b", got.fault, w.fault));
        endfunction
    endclass

    logic               clk = 0;
    logic               rst_n = 0;
    logic               item_valid = 0;
    logic               item_ready;
    logic [1:0]         mode = MODE_CLEAR;
    logic [IDX_W-1:0]   vertex_index = 0;
    logic signed [23:0] pos_x = 0;
    logic signed [23:0] pos_y = 0;
    logic signed [23:0] pos_z = 0;
    nrm_t               given_normal_x = 0;
    nrm_t               given_normal_y = 0;
    nrm_t               given_normal_z = 0;
    logic [IDX_W-1:0]   corner_b = 0;
    logic [IDX_W-1:0]   corner_c = 0;
    logic               result_valid;
    logic               result_ready = 0;
    nrm_t               normal_x;
    nrm_t               normal_y;
    nrm_t               normal_z;
    logic               generated;
    logic               index_fault;
    logic               cfg_we = 0;
    logic [1:0]         cfg_index = 0;
    logic [CFG_W-1:0]   cfg_data = 0;

    normal_scoreboard sb;
    bit               calm = 0;
    bit               loaded[NV];
    int               stall_cycles = 0;

    vertex_normal_generator u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .mode           (mode),
        .vertex_index   (vertex_index),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .pos_z          (pos_z),
        .given_normal_x (given_normal_x),
        .given_normal_y (given_normal_y),
        .given_normal_z (given_normal_z),
        .corner_b       (corner_b),
        .corner_c       (corner_c),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .normal_x       (normal_x),
        .normal_y       (normal_y),
        .normal_z       (normal_z),
        .generated      (generated),
        .index_fault    (index_fault),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #4 clk = ~clk;

    // receiver: random bursts of stall and accept
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 3) == 0)
            begin
                result_ready = 0;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
            else
            begin
                result_ready = 1;
                repeat ($urandom_range(0, 7)) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_result('{normal_x, normal_y, normal_z, generated, index_fault});
    end

    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("vertex_normal_generator: mismatch");
            $finish;
        end
    end

    task automatic send_item(logic [1:0] md, logic [IDX_W-1:0] vi,
                             logic signed [23:0] x, logic signed [23:0] y,
                             logic signed [23:0] z, nrm_t gx, nrm_t gy, nrm_t gz,
                             logic [IDX_W-1:0] cb, logic [IDX_W-1:0] cc);
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            @(negedge clk);
            item_valid = 0;
            repeat ($urandom_range(0, 7)) @(negedge clk);
        end
        @(negedge clk);
        item_valid     = 1;
        mode           = md;
        vertex_index   = vi;
        pos_x          = x;
        pos_y          = y;
        pos_z          = z;
        given_normal_x = gx;
        given_normal_y = gy;
        given_normal_z = gz;
        corner_b       = cb;
        corner_c       = cc;
        forever
        begin
            @(posedge clk);
            if (item_ready)
                break;
        end
        sb.note_item(md, vi, x, y, z, gx, gy, gz, cb, cc);
        if (md == MODE_LOAD)
            loaded[vi] = 1;
    endtask

    task automatic load_vertex(int vi, bit bad_normal);
        logic signed [23:0] p[3];
        nrm_t               g[3];
        for (int i = 0; i < 3; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                p[i] = 24'(int'($urandom_range(0, 2047)) - 1024);
            else
                p[i] = 24'($urandom);
            if (bad_normal)
                g[i] = 16'(int'($urandom_range(0, 20)) - 10);
            else
                g[i] = 16'(int'($urandom_range(0, 32768)) - 16384);
        end
        send_item(MODE_LOAD, IDX_W'(vi), p[0], p[1], p[2], g[0], g[1], g[2],
                  IDX_W'($urandom), IDX_W'($urandom));
    endtask

    task automatic simple_item(logic [1:0] md, int a, int b, int c);
        send_item(md, IDX_W'(a), 24'($urandom), 24'($urandom), 24'($urandom),
                  16'($urandom), 16'($urandom), 16'($urandom), IDX_W'(b), IDX_W'(c));
    endtask

    task automatic settle_and_config(logic [VC_W-1:0] vc, logic [VT_W-1:0] vt,
                                     logic [DT_W-1:0] dt);
        @(negedge clk);
        item_valid = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(negedge clk);
        for (int r = 0; r < 3; r++)
        begin
            cfg_we    = 1;
            cfg_index = (r == 0) ? REG_VERTEX_COUNT : (r == 1) ? REG_VALID_THR : REG_DEGEN_THR;
            cfg_data  = (r == 0) ? CFG_W'(vc) : (r == 1) ? CFG_W'(vt) : CFG_W'(dt);
            sb.set_reg(cfg_index, cfg_data);
            @(negedge clk);
        end
        cfg_we = 0;
    endtask

    // corner or read index: a loaded entry below the count, or one at or above it
    function automatic int pick_index(int cnt, bit want_bad);
        int cand[$];
        if (want_bad && cnt < NV)
            return $urandom_range(cnt, NV - 1);
        for (int i = 0; i < cnt; i++)
            if (loaded[i])
                cand = {cand, i};
        if (cand.size() == 0)
            return (cnt < NV) ? $urandom_range(cnt, NV - 1) : -1;
        return cand[$urandom_range(0, cand.size() - 1)];
    endfunction

    task automatic random_phase(int n_items);
        int cnt;
        int a, b, c, r;
        cnt = sb.in_use();
        simple_item(MODE_CLEAR, 0, 0, 0);
        repeat ($urandom_range(3, 24))
        begin
            a = (cnt > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, cnt - 1)
                                                       : $urandom_range(0, NV - 1);
            load_vertex(a, $urandom_range(0, 3) == 0);
        end
        for (int n = 0; n < n_items; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 12)
            begin
                a = (cnt > 0) ? $urandom_range(0, cnt - 1) : $urandom_range(0, NV - 1);
                load_vertex(a, $urandom_range(0, 3) == 0);
            end
            else if (r < 55)
            begin
                a = pick_index(cnt, $urandom_range(0, 9) == 0);
                b = pick_index(cnt, 0);
                c = pick_index(cnt, 0);
                if (a >= 0 && b >= 0 && c >= 0)
                    simple_item(MODE_TRI, a, b, c);
            end
            else if (r < 95)
            begin
                a = pick_index(cnt, $urandom_range(0, 7) == 0);
                if (a >= 0)
                    simple_item(MODE_READ, a, 0, 0);
            end
            else
                simple_item(MODE_CLEAR, 0, 0, 0);
        end
    endtask

    initial
    begin
        logic [VC_W-1:0] vc;
        logic [VT_W-1:0] vt;
        logic [DT_W-1:0] dt;
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: extremes, pass-through, generated, bad corner, fault, degenerate
        settle_and_config(13'd8, VT_RESET, DT_RESET);
        send_item(MODE_LOAD, 0, 24'sh7FFFFF, 24'sh800000, 0, 16'sd16384, 0, 0, 0, 0);
        send_item(MODE_LOAD, 1, 24'sh800000, 24'sh7FFFFF, 24'sh7FFFFF,
                  -16'sd16384, -16'sd16384, -16'sd16384, 0, 0);
        send_item(MODE_LOAD, 2, 0, 0, 24'sh800000, 0, 0, 0, 0, 0);
        send_item(MODE_LOAD, 3, 24'sd5, 24'sd5, 24'sd5, 1, -1, 1, 0, 0);
        simple_item(MODE_READ, 0, 0, 0);
        simple_item(MODE_TRI, 0, 1, 2);
        simple_item(MODE_READ, 0, 0, 0);
        simple_item(MODE_READ, 2, 0, 0);
        simple_item(MODE_TRI, 0, 1, 9);
        simple_item(MODE_READ, 9, 0, 0);
        simple_item(MODE_READ, 4095, 0, 0);
        simple_item(MODE_TRI, 3, 3, 3);
        simple_item(MODE_READ, 3, 0, 0);
        simple_item(MODE_CLEAR, 0, 0, 0);
        simple_item(MODE_READ, 1, 0, 0);
        simple_item(MODE_TRI, 0, 1, 2);
        simple_item(MODE_READ, 1, 0, 0);
        // a load past the count still flags its invalid normal
        send_item(MODE_LOAD, 4095, 0, 0, 0, 0, 0, 0, 0, 0);
        simple_item(MODE_READ, 2, 0, 0);
        simple_item(MODE_READ, 1, 0, 0);

        for (int ph = 0; ph < 16; ph++)
        begin
            case (ph % 6)
                0: vc = 13'd3;
                1: vc = 13'd8191;
                2: vc = 13'd4096;
                3: vc = 13'd0;
                4: vc = 13'd4095;
                default: vc = VC_W'($urandom_range(3, 40));
            endcase
            case (ph % 5)
                0: vt = 30'd0;
                1: vt = 30'h3FFF_FFFF;
                2: vt = VT_RESET;
                3: vt = 30'd1 << 28;
                default: vt = VT_W'($urandom);
            endcase
            case (ph % 4)
                0: dt = ($urandom_range(0, 1) == 0) ? DT_RESET : 63'd0;
                1: dt = {63{1'b1}};
                2: dt = 63'd0;
                default: dt = DT_W'({$urandom, $urandom});
            endcase
            if (ph >= 14)
                calm = 1;
            settle_and_config(vc, vt, dt);
            random_phase(90);
        end

        @(negedge clk);
        item_valid = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("vertex_normal_generator: match");
        else
            $display("vertex_normal_generator: mismatch");
        $finish;
    end

endmodule
